// ----- src/idbc_pkg.sv -----
package idbc_pkg;

   localparam int IDLE_W      = 32;
   localparam int SEC_W       = 16;
   localparam int MS_W        = 26;
   localparam int ALPHA_W     = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int MS_PER_S    = 1000;
   localparam int FADE_MS_DEF = 1500;

   localparam logic [SEC_W-1:0]   WARN_S_RST   = 16'd10;
   localparam logic [SEC_W-1:0]   BLACK_S_RST  = 16'd20;
   localparam logic [ALPHA_W-1:0] MAX_DIM_RST  = 16'd42598;

   typedef enum logic [1:0] {
      MODE_NORMAL   = 2'd0,
      MODE_DIMMING  = 2'd1,
      MODE_BLACKOUT = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WARN     = 2'd0,
      CSR_BLACKOUT = 2'd1,
      CSR_MAX_DIM  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [IDLE_W-1:0] idle_ms;
      logic              media_active;
   } req_type;

   typedef struct packed {
      mode_type           mode;
      logic [ALPHA_W-1:0] alpha;
      logic               paint;
      logic               show_overlay;
      logic               hide_overlay;
      logic               standby_now;
      logic               wake_now;
   } rsp_type;

   typedef struct packed {
      mode_type mode;
      logic     paint;
      logic     show_overlay;
      logic     hide_overlay;
      logic     standby_now;
      logic     wake_now;
   } side_type;

   typedef struct packed {
      logic [MS_W-1:0]    warn_ms;
      logic [MS_W-1:0]    black_ms;
      logic [ALPHA_W-1:0] max_dim;
   } cfg_type;

endpackage

// ----- src/idbc_csr.sv -----
module idbc_csr
   import idbc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SEC_W-1:0]     csr_data,
   output cfg_type              cfg
);

   cfg_type         cfg_ff;
   cfg_type         cfg_in;
   logic [MS_W-1:0] data_ms;

   // thresholds kept in milliseconds
   assign data_ms   = MS_W'(csr_data) * MS_W'(MS_PER_S);
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_WARN:     cfg_in.warn_ms  = data_ms;
            CSR_BLACKOUT: cfg_in.black_ms = data_ms;
            CSR_MAX_DIM:  cfg_in.max_dim  = csr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.warn_ms  <= MS_W'(WARN_S_RST) * MS_W'(MS_PER_S);
         cfg_ff.black_ms <= MS_W'(BLACK_S_RST) * MS_W'(MS_PER_S);
         cfg_ff.max_dim  <= MAX_DIM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- src/idbc_mode.sv -----
module idbc_mode
   import idbc_pkg::*;
#(
   parameter int FADE_MS = FADE_MS_DEF,
   localparam int TW = $clog2(FADE_MS + 1)
)(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  logic          take,
   input  req_type       req,
   input  cfg_type       cfg,
   output side_type      side,
   output logic [TW-1:0] fade_t
);

   mode_type          mode_ff;
   mode_type          mode_in;
   side_type          side_ff;
   side_type          side_in;
   logic [TW-1:0]     fade_t_ff;
   logic [TW-1:0]     fade_t_in;
   logic [IDLE_W-1:0] idle;
   logic [IDLE_W-1:0] past_warn;
   logic              black_hit;
   logic              warn_hit;

   assign idle      = req.media_active ? '0 : req.idle_ms;
   assign black_hit = idle >= IDLE_W'(cfg.black_ms);
   assign warn_hit  = idle >= IDLE_W'(cfg.warn_ms);
   assign past_warn = idle - IDLE_W'(cfg.warn_ms);

   always_comb begin
      side_in   = '0;
      fade_t_in = '0;
      if (black_hit) begin
         side_in.mode        = MODE_BLACKOUT;
         side_in.standby_now = (mode_ff != MODE_BLACKOUT);
      end else if (warn_hit) begin
         side_in.mode         = MODE_DIMMING;
         side_in.paint        = 1'b1;
         side_in.wake_now     = (mode_ff == MODE_BLACKOUT);
         side_in.show_overlay = (mode_ff != MODE_DIMMING);
         fade_t_in = (past_warn > IDLE_W'(FADE_MS)) ? TW'(FADE_MS) : past_warn[TW-1:0];
      end else begin
         side_in.mode         = MODE_NORMAL;
         side_in.wake_now     = (mode_ff == MODE_BLACKOUT);
         side_in.hide_overlay = (mode_ff != MODE_NORMAL);
      end
      mode_in = take ? side_in.mode : mode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         side_ff   <= side_in;
         fade_t_ff <= fade_t_in;
      end
   end

   assign side   = side_ff;
   assign fade_t = fade_t_ff;

endmodule

// ----- src/idbc_scale.sv -----
module idbc_scale
   import idbc_pkg::*;
#(
   parameter int FADE_MS = FADE_MS_DEF,
   localparam int TW = $clog2(FADE_MS + 1)
)(
   input  logic               clock,
   input  logic [1:0]         load,
   input  side_type           side,
   input  logic [TW-1:0]      fade_t,
   input  logic [ALPHA_W-1:0] max_dim,
   output rsp_type            rsp
);

   localparam int PW = TW + ALPHA_W;
   localparam int SH = PW + TW;
   localparam int KW = PW + 2;
   localparam int QW = PW + KW;
   localparam logic [KW-1:0] RECIP =
      KW'(((64'd1 << SH) + 64'(FADE_MS) - 64'd1) / 64'(FADE_MS));

   logic [PW-1:0]      prod_ff;
   logic [PW-1:0]      prod_in;
   side_type           prod_side_ff;
   logic [QW-1:0]      scaled;
   logic [ALPHA_W-1:0] quo_in;
   logic [ALPHA_W-1:0] quo_ff;
   side_type           side_ff;

   assign prod_in = PW'(fade_t) * PW'(max_dim);

   // floor(prod / FADE_MS): multiply by the rounded-up reciprocal, exact for every product
   assign scaled = QW'(prod_ff) * QW'(RECIP);
   assign quo_in = scaled[SH +: ALPHA_W];

   always_ff @(posedge clock) begin
      if (load[0]) begin
         prod_ff      <= prod_in;
         prod_side_ff <= side;
      end
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         quo_ff  <= quo_in;
         side_ff <= prod_side_ff;
      end
   end

   always_comb begin
      rsp.mode         = side_ff.mode;
      rsp.alpha        = quo_ff;
      rsp.paint        = side_ff.paint;
      rsp.show_overlay = side_ff.show_overlay;
      rsp.hide_overlay = side_ff.hide_overlay;
      rsp.standby_now  = side_ff.standby_now;
      rsp.wake_now     = side_ff.wake_now;
   end

endmodule

// ----- src/idle_dim_blackout_controller.sv -----
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_stall | req_type: idle_ms, media_active
// rsp     | out       | rsp_valid / rsp_stall | rsp_type: mode, alpha, paint, pulses
// csr     | in        | csr_valid / csr_ready | csr_index, csr_data (16 bit)
//
// One transaction per cycle sustained while rsp_stall is low; a request passes the
// input register, mode stage, fade product, then the divide by FADE_MS done as
// a multiply by its rounded-up reciprocal, on its way to the result.
// Synchronous reset: mode to normal, CSR registers to defaults, pipeline empty.
// rsp_stall holds the result register; empty stages keep filling behind it and
// req_stall rises only once every stage holds a transaction.
module idle_dim_blackout_controller
   import idbc_pkg::*;
#(
   parameter int FADE_MS = FADE_MS_DEF
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SEC_W-1:0]     csr_data
);

   localparam int TW = $clog2(FADE_MS + 1);
   localparam int N  = 4;

   logic [N-1:0]  valid_ff;
   logic [N-1:0]  valid_in;
   logic [N:0]    ready;
   req_type       req_ff;
   cfg_type       cfg;
   side_type      side;
   logic [TW-1:0] fade_t;

   assign ready[N] = !rsp_stall;
   for (genvar i = 0; i < N; i++) begin : g_flow
      assign ready[i] = !valid_ff[i] || ready[i+1];
      if (i == 0) begin : g_head
         assign valid_in[i] = ready[i] ? req_valid : valid_ff[i];
      end else begin : g_body
         assign valid_in[i] = ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         req_ff <= req_payload;
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[N-1];

   idbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   idbc_mode #(
      .FADE_MS (FADE_MS)
   ) u_mode (
      .clock  (clock),
      .reset  (reset),
      .load   (ready[1]),
      .take   (ready[1] && valid_ff[0]),
      .req    (req_ff),
      .cfg    (cfg),
      .side   (side),
      .fade_t (fade_t)
   );

   idbc_scale #(
      .FADE_MS (FADE_MS)
   ) u_scale (
      .clock   (clock),
      .load    (ready[N-1:2]),
      .side    (side),
      .fade_t  (fade_t),
      .max_dim (cfg.max_dim),
      .rsp     (rsp_payload)
   );

`ifndef SYNTHESIS
   a_alpha_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.alpha <= cfg.max_dim)
      else $error("alpha above max dim level");

   a_alpha_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.paint |-> rsp_payload.alpha == '0)
      else $error("alpha nonzero without paint");

   a_standby_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.standby_now |-> rsp_payload.mode == MODE_BLACKOUT)
      else $error("standby pulse outside blackout");

   a_paint_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.paint == (rsp_payload.mode == MODE_DIMMING))
      else $error("paint does not track dimming mode");
`endif

endmodule

// ----- tb/sv/idbc_checker.sv -----
module idbc_checker
   import idbc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_type              req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_type              rsp_payload,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SEC_W-1:0]     csr_data,
   output int                   failures,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [SEC_W-1:0]   warn_s;
   logic [SEC_W-1:0]   black_s;
   logic [ALPHA_W-1:0] max_dim;
   mode_type           mode_now;
   rsp_type            predicted_rsps[$];
   int                 mismatches;

   function automatic rsp_type predict_poll(req_type poll, mode_type prior);
      logic [31:0] idle;
      logic [31:0] warn_ms;
      logic [31:0] black_ms;
      logic [31:0] ramp;
      logic [63:0] scaled;
      rsp_type     r;
      r = '0;
      r.mode = prior;
      idle = poll.media_active ? 32'd0 : poll.idle_ms;
      warn_ms = {16'd0, warn_s} * MS_PER_S;
      black_ms = {16'd0, black_s} * MS_PER_S;
      if (idle >= black_ms) begin
         if (prior != MODE_BLACKOUT) begin
            r.mode = MODE_BLACKOUT;
            r.standby_now = 1'b1;
         end
      end else if (idle >= warn_ms) begin
         ramp = idle - warn_ms;
         r.wake_now = (prior == MODE_BLACKOUT);
         r.show_overlay = (prior != MODE_DIMMING);
         r.mode = MODE_DIMMING;
         if (ramp > FADE_MS_DEF) ramp = FADE_MS_DEF;
         scaled = {32'd0, ramp} * {48'd0, max_dim};
         r.alpha = ALPHA_W'(scaled / FADE_MS_DEF);
         r.paint = 1'b1;
      end else begin
         r.wake_now = (prior == MODE_BLACKOUT);
         r.hide_overlay = (prior != MODE_NORMAL);
         r.mode = MODE_NORMAL;
      end
      return r;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         warn_s = WARN_S_RST;
         black_s = BLACK_S_RST;
         max_dim = MAX_DIM_RST;
         mode_now = MODE_NORMAL;
         predicted_rsps.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WARN:     warn_s = csr_data;
               CSR_BLACKOUT: black_s = csr_data;
               CSR_MAX_DIM:  max_dim = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            want = predict_poll(req_payload, mode_now);
            mode_now = want.mode;
            predicted_rsps.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: result transaction with none expected", $realtime);
            end else begin
               want = predicted_rsps.pop_front();
               check_field("mode", want.mode, rsp_payload.mode);
               check_field("alpha", want.alpha, rsp_payload.alpha);
               check_field("paint", want.paint, rsp_payload.paint);
               check_field("show_overlay", want.show_overlay, rsp_payload.show_overlay);
               check_field("hide_overlay", want.hide_overlay, rsp_payload.hide_overlay);
               check_field("standby_now", want.standby_now, rsp_payload.standby_now);
               check_field("wake_now", want.wake_now, rsp_payload.wake_now);
            end
         end
      end
      pending <= predicted_rsps.size();
      failures <= mismatches;
   end

endmodule

// ----- tb/sv/tb.sv -----
module tb
   import idbc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SEC_W-1:0]     csr_data = '0;
   int                   failures;
   int                   pending;
   int                   cycles = 0;
   bit                   idling_on = 1'b1;
   bit                   hold_off_go = 1'b0;
   logic [SEC_W-1:0]     warn_cfg = WARN_S_RST;
   logic [SEC_W-1:0]     black_cfg = BLACK_S_RST;

   idle_dim_blackout_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   idbc_checker poll_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .failures    (failures),
      .pending     (pending)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            rsp_stall <= 1'b1;
            repeat (60) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_poll(logic [IDLE_W-1:0] idle, logic media);
      if (idling_on && $urandom_range(0, 6) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{idle_ms: idle, media_active: media};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_polls();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_reg(csr_index_type idx, logic [SEC_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic write_cfg(logic [SEC_W-1:0] warn_s, logic [SEC_W-1:0] black_s,
                            logic [ALPHA_W-1:0] max_dim);
      write_reg(CSR_WARN, warn_s);
      write_reg(CSR_BLACKOUT, black_s);
      write_reg(CSR_MAX_DIM, max_dim);
      csr_valid <= 1'b0;
      warn_cfg = warn_s;
      black_cfg = black_s;
   endtask

   // aim idle times at the thresholds of the current setting
   function automatic logic [IDLE_W-1:0] pick_idle();
      logic [31:0] warn_ms;
      logic [31:0] black_ms;
      warn_ms = {16'd0, warn_cfg} * MS_PER_S;
      black_ms = {16'd0, black_cfg} * MS_PER_S;
      case ($urandom_range(0, 9))
         0, 1:    return (warn_ms == 0) ? 32'd0 : $urandom_range(0, warn_ms - 1);
         2, 3:    return warn_ms + $urandom_range(0, FADE_MS_DEF + 200);
         4: begin
            case ($urandom_range(0, 3))
               0:       return warn_ms - 1;
               1:       return warn_ms;
               2:       return warn_ms + FADE_MS_DEF;
               default: return warn_ms + FADE_MS_DEF + 1;
            endcase
         end
         5:       return black_ms - 1 + $urandom_range(0, 2);
         6:       return black_ms + $urandom_range(0, 100000);
         7:       return $urandom();
         8:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
         default: return warn_ms + $urandom_range(0, black_ms - warn_ms + 3000);
      endcase
   endfunction

   task automatic run_phase(int count, bit hold_off, bit pause);
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) idling_on = ($urandom_range(0, 3) != 0);
         if (hold_off && n == count / 2) hold_off_go = 1'b1;
         if (pause && n == count / 3) drain_polls();
         send_poll(pick_idle(), $urandom_range(0, 7) == 0);
      end
      drain_polls();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // defaults: warn 10 s, blackout 20 s
      send_poll(32'd0, 1'b0);
      send_poll(32'hFFFF_FFFF, 1'b1);
      send_poll(32'd9999, 1'b0);
      send_poll(32'd10000, 1'b0);
      send_poll(32'd10750, 1'b0);
      send_poll(32'd11500, 1'b0);
      send_poll(32'd11501, 1'b0);
      send_poll(32'd19999, 1'b0);
      send_poll(32'd20000, 1'b0);
      send_poll(32'd15000, 1'b0);
      send_poll(32'd0, 1'b0);
      send_poll(32'hFFFF_FFFF, 1'b0);
      send_poll(32'd5, 1'b0);
      send_poll(32'hAAAA_AAAA, 1'b0);
      send_poll(32'h5555_5555, 1'b1);
      send_poll(32'd12000, 1'b0);
      send_poll(32'd25000, 1'b0);
      send_poll(32'd30000, 1'b1);
      drain_polls();

      write_cfg(16'd0, 16'd1, 16'hFFFF);
      run_phase(170, 1'b0, 1'b0);
      write_cfg(16'd5, 16'd3, 16'd1000);
      run_phase(170, 1'b0, 1'b0);
      write_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_phase(170, 1'b0, 1'b0);
      write_cfg(16'hFFFE, 16'hFFFF, 16'd0);
      run_phase(170, 1'b0, 1'b0);
      write_cfg(16'd1, 16'd2, 16'd32768);
      run_phase(170, 1'b1, 1'b0);
      write_cfg(16'd2, 16'd4, 16'd1);
      run_phase(170, 1'b0, 1'b1);
      write_cfg(16'd0, 16'd0, 16'd0);
      run_phase(170, 1'b0, 1'b0);
      write_cfg(16'd3, 16'd30, 16'd12345);
      run_phase(170, 1'b0, 1'b0);
      write_cfg(WARN_S_RST, BLACK_S_RST, MAX_DIM_RST);
      idling_on = 1'b0;
      for (int n = 0; n < 170; n++) send_poll(pick_idle(), $urandom_range(0, 7) == 0);
      drain_polls();

      repeat (30) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
